@@ hw/rtl/hvd_pkg.sv @@
package hvd_pkg;

  localparam int NUM_STATES = 4;
  localparam int STATE_W    = 2;
  localparam int GEN_W      = 3;
  localparam int METRIC_W   = 8;
  localparam int CNT_W      = 7;
  localparam int CFG_IDX_W  = 1;

  typedef logic [GEN_W-1:0]      gen_t;
  typedef logic [METRIC_W-1:0]   metric_t;
  typedef logic [STATE_W-1:0]    state_t;
  typedef logic [NUM_STATES-1:0] dec_t;
  typedef logic [CNT_W-1:0]      count_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GEN_FIRST  = 1'b0,
    REG_GEN_SECOND = 1'b1
  } reg_idx_t;

  localparam gen_t GEN_FIRST_RST  = 3'd5;
  localparam gen_t GEN_SECOND_RST = 3'd7;

  typedef struct packed {
    logic                             valid;
    logic                             bank;
    count_t                           count;
    metric_t [NUM_STATES-1:0]         metric;
    logic [NUM_STATES-1:0]            reached;
  } acs_done_t;

  typedef struct packed {
    logic    valid;
    logic    bank;
    count_t  count;
    metric_t metric;
  } tb_done_t;

endpackage

@@ hw/rtl/hvd_sym_if.sv @@
interface hvd_sym_if;
  logic valid;
  logic ready;
  logic rx_first;
  logic rx_second;
  logic frame_end;

  modport source (output valid, output rx_first, output rx_second, output frame_end,
                  input ready);
  modport sink (input valid, input rx_first, input rx_second, input frame_end,
                output ready);
endinterface

@@ hw/rtl/hvd_res_if.sv @@
interface hvd_res_if;
  logic                    valid;
  logic                    ready;
  logic                    decoded_bit;
  logic                    last_of_frame;
  logic [hvd_pkg::METRIC_W-1:0] best_metric;

  modport source (output valid, output decoded_bit, output last_of_frame,
                  output best_metric, input ready);
  modport sink (input valid, input decoded_bit, input last_of_frame,
                input best_metric, output ready);
endinterface

@@ hw/rtl/hvd_cfg_if.sv @@
interface hvd_cfg_if;
  logic                   valid;
  logic                   ready;
  hvd_pkg::reg_idx_t      index;
  logic [hvd_pkg::GEN_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/hard_viterbi_decoder_k3.sv @@
// Hard-decision Viterbi decoder for the rate-1/2, constraint-length-3 code with
// four trellis states and programmable generator masks (5 and 7 after reset; a write
// takes effect from the next pair on). One received pair can be taken every clock
// while the decision bank in use is free: add-compare-select is combinational and
// stores one decision word per pair in a two-bank decision memory. At the end of a
// frame of N pairs, a traceback unit walks back from the best reached state, one
// memory read per cycle, and writes the decoded bits into a two-bank bit memory; a
// read-out stage then delivers them oldest first, one beat per cycle while the result
// side is ready. With two banks in each memory the three stages overlap, so long
// frames stream at nearly one pair per cycle, since each traceback lasts longer than
// its frame; frames shorter than the traceback time, or a stalled output, hold off
// new pairs until a bank frees. With the traceback and read-out idle, a frame's first
// decoded bit is valid once traceback has written it and read-out has read it back.
module hard_viterbi_decoder_k3 #(
  parameter int MAX_FRAME = 64
) (
  input  logic       clk,
  input  logic       rst,
  hvd_cfg_if.sink    cfg,
  hvd_sym_if.sink    sym,
  hvd_res_if.source  res
);

  localparam int POS_W     = $clog2(MAX_FRAME);
  localparam int RAM_DEPTH = 2 * (2 ** POS_W);

  logic               dec_we;
  logic [POS_W:0]     dec_waddr;
  hvd_pkg::dec_t      dec_wdata;
  logic               dec_re;
  logic [POS_W:0]     dec_raddr;
  hvd_pkg::dec_t      dec_rdata;
  logic [1:0]         dec_busy;

  logic               bit_we;
  logic [POS_W:0]     bit_waddr;
  logic               bit_wdata;
  logic               bit_re;
  logic [POS_W:0]     bit_raddr;
  logic               bit_rdata;
  logic [1:0]         bit_busy;

  hvd_pkg::acs_done_t acs_done;
  hvd_pkg::tb_done_t  tb_done;

  hvd_acs #(.MAX_FRAME(MAX_FRAME)) u_acs (
    .clk       (clk),
    .rst       (rst),
    .sym       (sym),
    .cfg       (cfg),
    .dec_busy  (dec_busy),
    .dec_we    (dec_we),
    .dec_waddr (dec_waddr),
    .dec_wdata (dec_wdata),
    .done      (acs_done)
  );

  hvd_ram #(.WIDTH(hvd_pkg::NUM_STATES), .DEPTH(RAM_DEPTH)) u_dec_ram (
    .clk   (clk),
    .we    (dec_we),
    .waddr (dec_waddr),
    .wdata (dec_wdata),
    .re    (dec_re),
    .raddr (dec_raddr),
    .rdata (dec_rdata)
  );

  hvd_traceback #(.MAX_FRAME(MAX_FRAME)) u_traceback (
    .clk       (clk),
    .rst       (rst),
    .acs_done  (acs_done),
    .bit_busy  (bit_busy),
    .dec_busy  (dec_busy),
    .dec_re    (dec_re),
    .dec_raddr (dec_raddr),
    .dec_rdata (dec_rdata),
    .bit_we    (bit_we),
    .bit_waddr (bit_waddr),
    .bit_wdata (bit_wdata),
    .done      (tb_done)
  );

  hvd_ram #(.WIDTH(1), .DEPTH(RAM_DEPTH)) u_bit_ram (
    .clk   (clk),
    .we    (bit_we),
    .waddr (bit_waddr),
    .wdata (bit_wdata),
    .re    (bit_re),
    .raddr (bit_raddr),
    .rdata (bit_rdata)
  );

  hvd_outbuf #(.MAX_FRAME(MAX_FRAME)) u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .tb_done   (tb_done),
    .bit_busy  (bit_busy),
    .bit_re    (bit_re),
    .bit_raddr (bit_raddr),
    .bit_rdata (bit_rdata),
    .res       (res)
  );

endmodule

@@ hw/rtl/hvd_ram.sv @@
module hvd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/hvd_acs.sv @@
module hvd_acs #(
  parameter int MAX_FRAME = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  hvd_sym_if.sink                     sym,
  hvd_cfg_if.sink                     cfg,
  input  logic [1:0]                  dec_busy,
  output logic                        dec_we,
  output logic [$clog2(MAX_FRAME):0]  dec_waddr,
  output hvd_pkg::dec_t               dec_wdata,
  output hvd_pkg::acs_done_t          done
);

  localparam int POS_W = $clog2(MAX_FRAME);
  localparam hvd_pkg::count_t FRAME_LEN = hvd_pkg::count_t'(MAX_FRAME);

  hvd_pkg::gen_t                               gen_first;
  hvd_pkg::gen_t                               gen_second;
  hvd_pkg::metric_t [hvd_pkg::NUM_STATES-1:0]  metric;
  logic [hvd_pkg::NUM_STATES-1:0]              reached;
  hvd_pkg::count_t                             count;
  logic                                        bank;

  hvd_pkg::state_t  pred [hvd_pkg::NUM_STATES][2];
  logic [2:0]       win  [hvd_pkg::NUM_STATES][2];
  hvd_pkg::metric_t cand [hvd_pkg::NUM_STATES][2];
  hvd_pkg::metric_t [hvd_pkg::NUM_STATES-1:0] metric_next;
  logic [hvd_pkg::NUM_STATES-1:0]              reached_next;
  hvd_pkg::dec_t                               take_upper;
  hvd_pkg::count_t                             count_next;
  logic                                        acc;
  logic                                        fin;

  always_comb begin
    for (int ns = 0; ns < hvd_pkg::NUM_STATES; ns++) begin
      for (int k = 0; k < 2; k++) begin
        pred[ns][k] = {k[0], 1'(ns >> 1)};
        win[ns][k]  = {pred[ns][k], ns[0]};
        cand[ns][k] = metric[pred[ns][k]]
                    + hvd_pkg::metric_t'((^(win[ns][k] & gen_first)) ^ sym.rx_first)
                    + hvd_pkg::metric_t'((^(win[ns][k] & gen_second)) ^ sym.rx_second);
      end
      take_upper[ns]   = reached[pred[ns][1]] &&
                         (!reached[pred[ns][0]] || (cand[ns][1] < cand[ns][0]));
      reached_next[ns] = reached[pred[ns][0]] | reached[pred[ns][1]];
      if (take_upper[ns]) begin
        metric_next[ns] = cand[ns][1];
      end else if (reached[pred[ns][0]]) begin
        metric_next[ns] = cand[ns][0];
      end else begin
        metric_next[ns] = '0;
      end
    end
  end

  assign sym.ready  = !dec_busy[bank];
  assign cfg.ready  = 1'b1;
  assign acc        = sym.valid && sym.ready;
  assign count_next = count + hvd_pkg::count_t'(1);
  assign fin        = sym.frame_end || (count_next == FRAME_LEN);

  assign dec_we    = acc;
  assign dec_waddr = {bank, count[POS_W-1:0]};
  assign dec_wdata = take_upper;

  assign done.valid   = acc && fin;
  assign done.bank    = bank;
  assign done.count   = count_next;
  assign done.metric  = metric_next;
  assign done.reached = reached_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_first  <= hvd_pkg::GEN_FIRST_RST;
      gen_second <= hvd_pkg::GEN_SECOND_RST;
      metric     <= '0;
      reached    <= hvd_pkg::NUM_STATES'(1);
      count      <= '0;
      bank       <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          hvd_pkg::REG_GEN_FIRST:  gen_first  <= cfg.data;
          hvd_pkg::REG_GEN_SECOND: gen_second <= cfg.data;
        endcase
      end
      if (acc) begin
        if (fin) begin
          metric  <= '0;
          reached <= hvd_pkg::NUM_STATES'(1);
          count   <= '0;
          bank    <= ~bank;
        end else begin
          metric  <= metric_next;
          reached <= reached_next;
          count   <= count_next;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    acc && fin |=> (count == '0) && (reached == hvd_pkg::NUM_STATES'(1)))
    else $error("frame state not restarted after frame end");

  a_some_reached: assert property (@(posedge clk) disable iff (rst)
    reached != '0)
    else $error("no trellis state reached");
`endif

endmodule

@@ hw/rtl/hvd_traceback.sv @@
module hvd_traceback #(
  parameter int MAX_FRAME = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  hvd_pkg::acs_done_t          acs_done,
  input  logic [1:0]                  bit_busy,
  output logic [1:0]                  dec_busy,
  output logic                        dec_re,
  output logic [$clog2(MAX_FRAME):0]  dec_raddr,
  input  hvd_pkg::dec_t               dec_rdata,
  output logic                        bit_we,
  output logic [$clog2(MAX_FRAME):0]  bit_waddr,
  output logic                        bit_wdata,
  output hvd_pkg::tb_done_t           done
);

  localparam int POS_W = $clog2(MAX_FRAME);

  hvd_pkg::metric_t [hvd_pkg::NUM_STATES-1:0] desc_metric [2];
  logic [hvd_pkg::NUM_STATES-1:0]             desc_reached [2];
  hvd_pkg::count_t                            desc_count [2];

  logic             bank;
  logic             run;
  logic [POS_W-1:0] idx;
  hvd_pkg::state_t  st;
  hvd_pkg::metric_t best_metric;

  hvd_pkg::state_t  best_st;
  hvd_pkg::metric_t best_m;
  logic             found;
  logic             start;
  hvd_pkg::count_t  cnt_m1;
  logic [POS_W-1:0] idx_m1;
  hvd_pkg::state_t  pred;

  always_comb begin
    found   = 1'b0;
    best_st = '0;
    best_m  = desc_metric[bank][0];
    for (int ns = 0; ns < hvd_pkg::NUM_STATES; ns++) begin
      if (desc_reached[bank][ns] && (!found || (desc_metric[bank][ns] < best_m))) begin
        found   = 1'b1;
        best_st = hvd_pkg::state_t'(ns);
        best_m  = desc_metric[bank][ns];
      end
    end
  end

  assign start  = !run && dec_busy[bank] && !bit_busy[bank];
  assign cnt_m1 = desc_count[bank] - hvd_pkg::count_t'(1);
  assign idx_m1 = idx - POS_W'(1);
  assign pred   = {dec_rdata[st], st[1]};

  assign dec_re    = start || run;
  assign dec_raddr = start ? {bank, cnt_m1[POS_W-1:0]} : {bank, idx_m1};

  assign bit_we    = run;
  assign bit_waddr = {bank, idx};
  assign bit_wdata = st[0];

  assign done.valid  = run && (idx == '0);
  assign done.bank   = bank;
  assign done.count  = desc_count[bank];
  assign done.metric = best_metric;

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_busy <= '0;
      bank     <= 1'b0;
      run      <= 1'b0;
    end else begin
      if (acs_done.valid) begin
        dec_busy[acs_done.bank]     <= 1'b1;
        desc_metric[acs_done.bank]  <= acs_done.metric;
        desc_reached[acs_done.bank] <= acs_done.reached;
        desc_count[acs_done.bank]   <= acs_done.count;
      end
      if (start) begin
        run         <= 1'b1;
        idx         <= cnt_m1[POS_W-1:0];
        st          <= best_st;
        best_metric <= best_m;
      end else if (run) begin
        if (idx == '0) begin
          run            <= 1'b0;
          dec_busy[bank] <= 1'b0;
          bank           <= ~bank;
        end else begin
          idx <= idx_m1;
          st  <= pred;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_dec_held: assert property (@(posedge clk) disable iff (rst)
    run |-> dec_busy[bank])
    else $error("decision bank released while being traced");

  a_bit_free: assert property (@(posedge clk) disable iff (rst)
    run |-> !bit_busy[bank])
    else $error("traceback writing into a bit bank that is being read out");
`endif

endmodule

@@ hw/rtl/hvd_outbuf.sv @@
module hvd_outbuf #(
  parameter int MAX_FRAME = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  hvd_pkg::tb_done_t           tb_done,
  output logic [1:0]                  bit_busy,
  output logic                        bit_re,
  output logic [$clog2(MAX_FRAME):0]  bit_raddr,
  input  logic                        bit_rdata,
  hvd_res_if.source                   res
);

  localparam int POS_W = $clog2(MAX_FRAME);

  hvd_pkg::count_t  desc_count [2];
  hvd_pkg::metric_t desc_metric [2];

  logic             bank;
  logic [POS_W-1:0] idx;
  logic             valid;
  logic             last;
  hvd_pkg::metric_t metric;

  logic             issue;
  hvd_pkg::count_t  last_idx;
  logic             is_last;

  assign issue     = bit_busy[bank] && (!valid || res.ready);
  assign last_idx  = desc_count[bank] - hvd_pkg::count_t'(1);
  assign is_last   = (idx == last_idx[POS_W-1:0]);
  assign bit_re    = issue;
  assign bit_raddr = {bank, idx};

  assign res.valid         = valid;
  assign res.decoded_bit   = bit_rdata;
  assign res.last_of_frame = last;
  assign res.best_metric   = metric;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_busy <= '0;
      bank     <= 1'b0;
      idx      <= '0;
      valid    <= 1'b0;
    end else begin
      if (tb_done.valid) begin
        bit_busy[tb_done.bank]    <= 1'b1;
        desc_count[tb_done.bank]  <= tb_done.count;
        desc_metric[tb_done.bank] <= tb_done.metric;
      end
      if (issue) begin
        valid  <= 1'b1;
        last   <= is_last;
        metric <= desc_metric[bank];
        if (is_last) begin
          bit_busy[bank] <= 1'b0;
          bank           <= ~bank;
          idx            <= '0;
        end else begin
          idx <= idx + POS_W'(1);
        end
      end else if (res.ready) begin
        valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_in_frame: assert property (@(posedge clk) disable iff (rst)
    bit_busy[bank] |-> (hvd_pkg::count_t'(idx) < desc_count[bank]))
    else $error("read-out index beyond frame length");
`endif

endmodule

@@ tb/sv/hard_viterbi_decoder_k3_tb.sv @@
module hard_viterbi_decoder_k3_tb;

  localparam int MAX_FRAME = 64;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic             value;
    logic             last;
    hvd_pkg::metric_t metric;
  } decoded_beat_t;

  // Tracks the four survivor paths the way the decoder should, and holds the
  // decoded beats that are still due on the result channel.
  class survivor_tracker;
    hvd_pkg::gen_t    tap_a;
    hvd_pkg::gen_t    tap_b;
    hvd_pkg::metric_t cost[hvd_pkg::NUM_STATES];
    bit               live[hvd_pkg::NUM_STATES];
    logic [63:0]      trail[hvd_pkg::NUM_STATES];
    int unsigned      pairs;
    decoded_beat_t    bits_due[$];
    int               errors;

    function new();
      tap_a  = hvd_pkg::GEN_FIRST_RST;
      tap_b  = hvd_pkg::GEN_SECOND_RST;
      errors = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < hvd_pkg::NUM_STATES; i++) begin
        cost[i]  = '0;
        live[i]  = 1'b0;
        trail[i] = '0;
      end
      live[0] = 1'b1;
      pairs   = 0;
    endfunction

    function void take_pair(bit r1, bit r2, bit fend);
      hvd_pkg::metric_t nd[hvd_pkg::NUM_STATES];
      bit               nl[hvd_pkg::NUM_STATES];
      logic [63:0]      nt[hvd_pkg::NUM_STATES];
      logic [2:0]       w;
      logic [1:0]       p;
      bit               b;
      int unsigned      m;
      int unsigned      pos;
      int unsigned      cnt;
      int               sel;
      decoded_beat_t    beat;

      pos = pairs % 64;
      for (int ns = 0; ns < hvd_pkg::NUM_STATES; ns++) begin
        b      = ns[0];
        nl[ns] = 1'b0;
        nd[ns] = '0;
        nt[ns] = '0;
        for (int k = 0; k < 2; k++) begin
          p = 2'(ns >> 1) + 2'(2 * k);
          w = {p, b};
          if (live[p]) begin
            m = cost[p] + ((^(w & tap_a)) != r1) + ((^(w & tap_b)) != r2);
            if (!nl[ns] || m < nd[ns]) begin
              nl[ns] = 1'b1;
              nd[ns] = hvd_pkg::metric_t'(m);
              nt[ns] = trail[p] | (64'(b) << pos);
            end
          end
        end
      end
      for (int ns = 0; ns < hvd_pkg::NUM_STATES; ns++) begin
        cost[ns]  = nd[ns];
        live[ns]  = nl[ns];
        trail[ns] = nt[ns];
      end
      pairs++;
      if (!fend && pairs < MAX_FRAME) return;

      cnt = (pairs > 64) ? 64 : pairs;
      sel = hvd_pkg::NUM_STATES;
      for (int ns = 0; ns < hvd_pkg::NUM_STATES; ns++) begin
        if (live[ns] && (sel == hvd_pkg::NUM_STATES || cost[ns] < cost[sel])) sel = ns;
      end
      if (sel == hvd_pkg::NUM_STATES) sel = 0;
      for (int k = 0; k < cnt; k++) begin
        beat.value  = trail[sel][k];
        beat.last   = (k == cnt - 1);
        beat.metric = cost[sel];
        bits_due    = {bits_due, beat};
      end
      restart();
    endfunction

    function void check_bit(logic value, logic last, hvd_pkg::metric_t metric);
      decoded_beat_t want;
      if (bits_due.size() == 0) begin
        $error("unexpected result beat: decoded_bit %0d last_of_frame %0d best_metric %0d",
               value, last, metric);
        errors++;
        return;
      end
      want = bits_due.pop_front();
      if (value !== want.value) begin
        $error("decoded_bit expected %0d actual %0d", want.value, value);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_of_frame expected %0d actual %0d", want.last, last);
        errors++;
      end
      if (metric !== want.metric) begin
        $error("best_metric expected %0d actual %0d", want.metric, metric);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycles;
  int   hold_left;
  int   burst_left;

  survivor_tracker sb;

  hvd_cfg_if cfg_ch();
  hvd_sym_if sym_ch();
  hvd_res_if res_ch();

  hard_viterbi_decoder_k3 #(.MAX_FRAME(MAX_FRAME)) DUT (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .sym (sym_ch),
    .res (res_ch)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("hard_viterbi_decoder_k3_tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      sb.check_bit(res_ch.decoded_bit, res_ch.last_of_frame, res_ch.best_metric);
    end
  end

  // The result side switches between always ready, random stalls and a
  // periodic pattern, unless a long hold-off is pending.
  initial begin
    int mode;
    int mode_left;
    int period;
    int tick;
    res_ch.ready = 1'b0;
    mode_left = 0;
    mode = 0;
    period = 2;
    tick = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 80);
          period    = $urandom_range(2, 5);
          tick      = 0;
        end
        mode_left--;
        tick++;
        case (mode)
          0: begin
            res_ch.ready = 1'b1;
          end
          1: begin
            res_ch.ready = 1'($urandom_range(0, 1));
          end
          default: begin
            res_ch.ready = (tick % period == 0);
          end
        endcase
      end
    end
  end

  task automatic idle_pairs(int n);
    repeat (n) begin
      @(negedge clk);
      sym_ch.valid = 1'b0;
    end
  endtask

  task automatic send_pair(bit r1, bit r2, bit fend);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) idle_pairs($urandom_range(1, 8));
      burst_left = ($urandom_range(0, 5) == 0) ? 100 : $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    sym_ch.valid     = 1'b1;
    sym_ch.rx_first  = r1;
    sym_ch.rx_second = r2;
    sym_ch.frame_end = fend;
    do @(posedge clk); while (sym_ch.ready !== 1'b1);
    sb.take_pair(r1, r2, fend);
  endtask

  task automatic write_gen(hvd_pkg::reg_idx_t idx, hvd_pkg::gen_t val);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    if (idx == hvd_pkg::REG_GEN_FIRST) sb.tap_a = val;
    else sb.tap_b = val;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic wait_all_decoded();
    idle_pairs(1);
    while (sb.bits_due.size() != 0) @(posedge clk);
  endtask

  // Encodes random information bits with the current masks and flips code
  // bits now and then, or sends plain noise.
  task automatic send_frame(int len, bit noise, bit mark_end, int flip_odds);
    logic [1:0] s;
    logic [2:0] w;
    bit b;
    bit r1;
    bit r2;
    s = 2'b00;
    for (int i = 0; i < len; i++) begin
      if (noise) begin
        r1 = 1'($urandom_range(0, 1));
        r2 = 1'($urandom_range(0, 1));
      end else begin
        b  = 1'($urandom_range(0, 1));
        w  = {s, b};
        r1 = ^(w & sb.tap_a);
        r2 = ^(w & sb.tap_b);
        if (flip_odds > 0 && $urandom_range(1, flip_odds) == 1) r1 = ~r1;
        if (flip_odds > 0 && $urandom_range(1, flip_odds) == 1) r2 = ~r2;
        s = {s[0], b};
      end
      send_pair(r1, r2, mark_end && (i == len - 1));
    end
  endtask

  task automatic run_frames(int budget, bit start_forced);
    int used;
    int len;
    int pick;
    bit mark_end;
    used = 0;
    while (used < budget) begin
      pick = $urandom_range(0, 9);
      if (start_forced && used == 0) pick = 0;
      if (pick == 0) begin
        len      = MAX_FRAME;
        mark_end = ($urandom_range(0, 3) == 0);
      end else if (pick == 1) begin
        len      = $urandom_range(33, MAX_FRAME - 1);
        mark_end = 1'b1;
      end else begin
        len      = $urandom_range(1, 16);
        mark_end = 1'b1;
      end
      send_frame(len, $urandom_range(0, 3) == 0, mark_end, $urandom_range(4, 16));
      used += len;
    end
  endtask

  task automatic set_gens(hvd_pkg::gen_t a, hvd_pkg::gen_t b);
    wait_all_decoded();
    repeat (MAX_FRAME + 20) @(posedge clk);
    write_gen(hvd_pkg::REG_GEN_FIRST, a);
    write_gen(hvd_pkg::REG_GEN_SECOND, b);
  endtask

  initial begin
    sb = new();
    cycles = 0;
    hold_left = 0;
    burst_left = 0;
    rst = 1'b1;
    sym_ch.valid = 1'b0;
    sym_ch.rx_first = 1'b0;
    sym_ch.rx_second = 1'b0;
    sym_ch.frame_end = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = hvd_pkg::REG_GEN_FIRST;
    cfg_ch.data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Single-pair frames with every received pair, then clean, noisy and
    // all-ones frames under the reset masks.
    send_pair(1'b0, 1'b0, 1'b1);
    send_pair(1'b0, 1'b1, 1'b1);
    send_pair(1'b1, 1'b0, 1'b1);
    send_pair(1'b1, 1'b1, 1'b1);
    send_frame(6, 1'b0, 1'b1, 0);
    send_frame(6, 1'b0, 1'b1, 3);
    repeat (4) send_pair(1'b1, 1'b1, 1'b0);
    send_pair(1'b1, 1'b1, 1'b1);
    run_frames(20, 1'b0);

    set_gens(3'd0, 3'd0);
    run_frames(20, 1'b1);

    // Short frames while the result side holds off fill every bank and
    // stall the input.
    set_gens(3'd7, 3'd7);
    @(posedge clk);
    hold_left = 400;
    repeat (6) send_frame(4, 1'b0, 1'b1, 8);
    run_frames(20, 1'b0);

    set_gens(3'd7, 3'd0);
    run_frames(10, 1'b0);
    wait_all_decoded();
    run_frames(10, 1'b0);

    set_gens(3'd0, 3'd7);
    run_frames(20, 1'b0);

    set_gens(3'd3, 3'd6);
    run_frames(20, 1'b0);

    set_gens(3'd1, 3'd4);
    run_frames(20, 1'b0);

    set_gens(hvd_pkg::gen_t'($urandom_range(0, 7)), hvd_pkg::gen_t'($urandom_range(0, 7)));
    run_frames(20, 1'b0);

    set_gens(hvd_pkg::GEN_FIRST_RST, hvd_pkg::GEN_SECOND_RST);
    run_frames(20, 1'b1);

    wait_all_decoded();
    repeat (MAX_FRAME + 20) @(posedge clk);
    if (sb.errors == 0 && sb.bits_due.size() == 0) begin
      $display("hard_viterbi_decoder_k3_tb passed");
    end else begin
      $display("hard_viterbi_decoder_k3_tb failed");
    end
    $finish;
  end

endmodule
